// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the colour ramp block.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/cri_pkg.sv =====
// Types, constants and the divide-by-255 helper for the colour ramp block.
// No dependencies; used by the interfaces and every module.
`default_nettype none

package cri_pkg;

    localparam int COUNT_W  = 5;
    localparam int IDX_W    = 4;
    localparam int COLOR_W  = 24;
    localparam int INT_W    = 8;
    localparam int CHAN_W   = 8;
    localparam int SCALED_W = 13;
    localparam int SEG_W    = 5;
    localparam int SUM_W    = 16;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    localparam logic [CHAN_W-1:0] RAMP_FULL = 8'd255;

    typedef struct packed {
        logic                is_load;
        logic [IDX_W-1:0]    entry_index;
        logic [COLOR_W-1:0]  entry_color;
        logic                zero_int;
        logic                empty;
        logic [SCALED_W-1:0] scaled;
    } scale_t;

    typedef struct packed {
        logic               zero_int;
        logic               empty;
        logic               prev_black;
        logic               next_zero;
        logic [CHAN_W-1:0]  frac;
        logic [COLOR_W-1:0] prev_color;
        logic [COLOR_W-1:0] next_color;
    } tap_t;

    // exact floor(x / 255) for quotients up to 256
    function automatic logic [8:0] div255(input logic [SUM_W-1:0] x);
        logic [SUM_W:0] t;
        t = 17'(x) + 17'(x >> 8) + 17'd1;
        return t[SUM_W:8];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cri_if.sv =====
// Valid/ready channel interfaces for request and response items.
// Depends on cri_pkg for field widths.
`default_nettype none

interface cri_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [cri_pkg::IDX_W-1:0]   entry_index;
    logic [cri_pkg::COLOR_W-1:0] entry_color;
    logic [cri_pkg::INT_W-1:0]   intensity;

    modport source (output valid, req_type, entry_index, entry_color, intensity,
                    input ready);
    modport sink (input valid, req_type, entry_index, entry_color, intensity,
                  output ready);
endinterface

interface cri_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [cri_pkg::CHAN_W-1:0] red;
    logic [cri_pkg::CHAN_W-1:0] green;
    logic [cri_pkg::CHAN_W-1:0] blue;
    logic                       color_valid;

    modport source (output valid, red, green, blue, color_valid, input ready);
    modport sink (input valid, red, green, blue, color_valid, output ready);
endinterface

`default_nettype wire

// ===== hdl/cri_scale.sv =====
// Entry stage: clamp the entry count and scale the intensity by it.
// Depends on cri_pkg and cri_req_if.
`default_nettype none

module cri_scale #(
    parameter int PALETTE_DEPTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    cri_req_if.sink                          req,
    input  wire logic [cri_pkg::COUNT_W-1:0] palette_count,
    output cri_pkg::scale_t                  s1_data,
    output logic                             s1_valid,
    input  wire logic                        s1_ready
);

    localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

    logic                            valid_reg;
    cri_pkg::scale_t                 data_reg;
    cri_pkg::scale_t                 data_next;
    logic [cri_pkg::COUNT_W-1:0]     count;
    logic                            accept;

    assign req.ready = !valid_reg || s1_ready;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        if (9'(palette_count) > DEPTH_LIM)
        begin
            count = DEPTH_LIM[cri_pkg::COUNT_W-1:0];
        end
        else
        begin
            count = palette_count;
        end
        data_next.is_load     = (req.req_type == cri_pkg::REQ_LOAD);
        data_next.entry_index = req.entry_index;
        data_next.entry_color = req.entry_color;
        data_next.zero_int    = (req.intensity == '0);
        data_next.empty       = (count == '0);
        data_next.scaled      = cri_pkg::SCALED_W'(req.intensity)
                              * cri_pkg::SCALED_W'(count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/cri_palette.sv =====
// Segment stage: split the scaled position into segment and fraction,
// write loads into the palette store and read both ramp neighbours.
// Depends on cri_pkg.
`default_nettype none

module cri_palette #(
    parameter int PALETTE_DEPTH = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cri_pkg::scale_t s1_data,
    input  wire logic            s1_valid,
    output logic                 s1_ready,
    output cri_pkg::tap_t        tap_data,
    output logic                 tap_valid,
    input  wire logic            tap_ready
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

    logic [cri_pkg::COLOR_W-1:0] mem [PALETTE_DEPTH];

    logic                            valid_reg;
    logic                            zero_int_reg;
    logic                            empty_reg;
    logic                            prev_black_reg;
    logic                            next_zero_reg;
    logic [cri_pkg::CHAN_W-1:0]      frac_reg;
    logic [cri_pkg::COLOR_W-1:0]     prev_color_reg;
    logic [cri_pkg::COLOR_W-1:0]     next_color_reg;

    logic [8:0]                      quot;
    logic [cri_pkg::SEG_W-1:0]       seg;
    logic [cri_pkg::SCALED_W-1:0]    seg_times;
    logic [cri_pkg::SCALED_W-1:0]    rem;
    logic [8:0]                      seg_ext;
    logic [8:0]                      prev_ext;
    logic [8:0]                      idx_ext;
    logic [AW-1:0]                   next_addr;
    logic [AW-1:0]                   prev_addr;
    logic [AW-1:0]                   wr_addr;
    logic                            adv;
    logic                            do_write;
    logic                            do_read;

    assign s1_ready = !valid_reg || tap_ready;
    assign adv      = s1_valid && s1_ready;
    assign do_write = adv && s1_data.is_load && (idx_ext < DEPTH_LIM);
    assign do_read  = adv && !s1_data.is_load;

    always_comb
    begin
        quot      = cri_pkg::div255(cri_pkg::SUM_W'(s1_data.scaled));
        seg       = quot[cri_pkg::SEG_W-1:0];
        seg_times = (cri_pkg::SCALED_W'(seg) << 8) - cri_pkg::SCALED_W'(seg);
        rem       = s1_data.scaled - seg_times;
        seg_ext   = 9'(seg);
        prev_ext  = seg_ext - 9'd1;
        idx_ext   = 9'(s1_data.entry_index);
        next_addr = seg_ext[AW-1:0];
        prev_addr = prev_ext[AW-1:0];
        wr_addr   = idx_ext[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_addr] <= s1_data.entry_color;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            prev_color_reg <= mem[prev_addr];
            next_color_reg <= mem[next_addr];
            zero_int_reg   <= s1_data.zero_int;
            empty_reg      <= s1_data.empty;
            prev_black_reg <= (seg == '0);
            next_zero_reg  <= (rem == '0);
            frac_reg       <= rem[cri_pkg::CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            valid_reg <= s1_valid && !s1_data.is_load;
        end
    end

    assign tap_valid           = valid_reg;
    assign tap_data.zero_int   = zero_int_reg;
    assign tap_data.empty      = empty_reg;
    assign tap_data.prev_black = prev_black_reg;
    assign tap_data.next_zero  = next_zero_reg;
    assign tap_data.frac       = frac_reg;
    assign tap_data.prev_color = prev_color_reg;
    assign tap_data.next_color = next_color_reg;

endmodule

`default_nettype wire

// ===== hdl/cri_blend.sv =====
// Blend stages: weight both neighbours per channel, then divide by 255
// into the output register. Depends on cri_pkg and cri_rsp_if.
`default_nettype none

module cri_blend (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cri_pkg::tap_t tap_data,
    input  wire logic          tap_valid,
    output logic               tap_ready,
    cri_rsp_if.source          rsp
);

    logic                                 a_valid_reg;
    logic                                 a_black_reg;
    logic                                 a_cvalid_reg;
    logic [2:0][cri_pkg::SUM_W-1:0]       sum_reg;
    logic [2:0][cri_pkg::SUM_W-1:0]       sum_next;
    logic [2:0][cri_pkg::CHAN_W-1:0]      p;
    logic [2:0][cri_pkg::CHAN_W-1:0]      n;
    logic [2:0][8:0]                      quot;
    logic [cri_pkg::CHAN_W-1:0]           wt_prev;
    logic                                 b_ready;
    logic                                 rsp_valid_reg;
    logic [2:0][cri_pkg::CHAN_W-1:0]      chan_reg;
    logic                                 cvalid_reg;

    assign b_ready   = !rsp_valid_reg || rsp.ready;
    assign tap_ready = !a_valid_reg || b_ready;
    assign wt_prev   = cri_pkg::RAMP_FULL - tap_data.frac;

    for (genvar k = 0; k < 3; k++)
    begin : g_chan
        localparam int SH = 16 - 8 * k;
        assign p[k] = tap_data.prev_black ? '0 : tap_data.prev_color[SH +: 8];
        assign n[k] = tap_data.next_zero  ? '0 : tap_data.next_color[SH +: 8];
        assign sum_next[k] = cri_pkg::SUM_W'(wt_prev) * cri_pkg::SUM_W'(p[k])
                           + cri_pkg::SUM_W'(tap_data.frac) * cri_pkg::SUM_W'(n[k]);
        assign quot[k] = cri_pkg::div255(sum_reg[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (tap_ready)
            begin
                a_valid_reg <= tap_valid;
            end
            if (b_ready)
            begin
                rsp_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tap_valid && tap_ready)
        begin
            sum_reg      <= sum_next;
            a_black_reg  <= tap_data.zero_int || tap_data.empty;
            a_cvalid_reg <= tap_data.zero_int || !tap_data.empty;
        end
        if (a_valid_reg && b_ready)
        begin
            for (int k = 0; k < 3; k++)
            begin
                chan_reg[k] <= a_black_reg ? '0 : quot[k][cri_pkg::CHAN_W-1:0];
            end
            cvalid_reg <= a_cvalid_reg;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.red         = chan_reg[0];
    assign rsp.green       = chan_reg[1];
    assign rsp.blue        = chan_reg[2];
    assign rsp.color_valid = cvalid_reg;

endmodule

`default_nettype wire

// ===== hdl/color_ramp_interpolator.sv =====
// Colour ramp interpolator top level: count register and pipeline wiring.
// Depends on cri_pkg, cri_if, cri_scale, cri_palette, cri_blend and
// assert_macros.svh.
//
// Usage:
//   req carries load items (req_type 1: write entry_color at entry_index)
//   and lookup items (req_type 0: map intensity onto the ramp). rsp carries
//   one item per lookup: red, green, blue and color_valid. Loads give none.
//   cfg_wr_en/cfg_wr_data set the number of ramp entries in use; write it
//   only while no items are in flight.
//   A lookup passes the scale register, the palette read, the weighting
//   and the divide/output register on its way to rsp.
//   A load is written into the palette store as it leaves the scale
//   register, so a lookup accepted directly after it already sees the new entry.
//   Throughput: one item per clock while rsp is not stalled, set by the
//   single-ported write and dual-ported registered read of the palette store.
//   Reset empties the pipeline and clears the entry count; palette
//   contents are undefined until loaded.
//   A stalled rsp holds its item; stages fill behind it, and req.ready
//   drops once every stage holds an item.
`default_nettype none
`include "assert_macros.svh"

module color_ramp_interpolator #(
    parameter int PALETTE_DEPTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    cri_req_if.sink                          req,
    cri_rsp_if.source                        rsp,
    input  wire logic                        cfg_wr_en,
    input  wire logic [cri_pkg::COUNT_W-1:0] cfg_wr_data
);

    logic [cri_pkg::COUNT_W-1:0] palette_count_reg;
    cri_pkg::scale_t             s1_data;
    logic                        s1_valid;
    logic                        s1_ready;
    cri_pkg::tap_t               tap_data;
    logic                        tap_valid;
    logic                        tap_ready;
    logic                        rsp_is_black;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            palette_count_reg <= cfg_wr_data;
        end
    end

    cri_scale #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .palette_count (palette_count_reg),
        .s1_data       (s1_data),
        .s1_valid      (s1_valid),
        .s1_ready      (s1_ready)
    );

    cri_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_data   (s1_data),
        .s1_valid  (s1_valid),
        .s1_ready  (s1_ready),
        .tap_data  (tap_data),
        .tap_valid (tap_valid),
        .tap_ready (tap_ready)
    );

    cri_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_data  (tap_data),
        .tap_valid (tap_valid),
        .tap_ready (tap_ready),
        .rsp       (rsp)
    );

    assign rsp_is_black = (rsp.red == '0) && (rsp.green == '0) && (rsp.blue == '0);

    `ASSERT_IMPLIES(a_invalid_is_black, clk, rst_n, rsp.valid && !rsp.color_valid, rsp_is_black)
    `ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid && !s1_ready, s1_valid && $stable(s1_data))
    `ASSERT_NEXT(a_tap_hold, clk, rst_n, tap_valid && !tap_ready, tap_valid && $stable(tap_data))

endmodule

`default_nettype wire

// ===== tb/sv/tb_color_ramp_interpolator.sv =====
// Self-checking bench for color_ramp_interpolator: palette loads, ramp lookups, count writes.
// A predictor, or a fixed expected colour, checks every lookup result against the block.
// Depends on cri_pkg, cri_if and the colour ramp RTL.
`default_nettype none

module tb_color_ramp_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PALETTE_DEPTH = 16;
    localparam int SETTLE_CYCLES = 10;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 90;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 135;

    typedef struct packed {
        logic [cri_pkg::CHAN_W-1:0] red;
        logic [cri_pkg::CHAN_W-1:0] green;
        logic [cri_pkg::CHAN_W-1:0] blue;
        logic                       color_valid;
    } ramp_colour_t;

    typedef enum logic [1:0] {STEP_COUNT, STEP_LOAD, STEP_LOOKUP} step_kind_t;

    typedef struct {
        step_kind_t                   kind;
        logic [cri_pkg::COUNT_W-1:0]  count;
        logic [cri_pkg::IDX_W-1:0]    index;
        logic [cri_pkg::COLOR_W-1:0]  colour;
        logic [cri_pkg::INT_W-1:0]    level;
        bit                           fixed;
        ramp_colour_t                 fixed_colour;
    } ramp_step_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [cri_pkg::COUNT_W-1:0] cfg_wr_data;

    cri_req_if req_ch();
    cri_rsp_if rsp_ch();

    color_ramp_interpolator #(.PALETTE_DEPTH(PALETTE_DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 clk = ~clk;

    logic [cri_pkg::COLOR_W-1:0] ramp_palette [PALETTE_DEPTH];
    logic [cri_pkg::COUNT_W-1:0] ramp_count;
    ramp_colour_t                expected_colours [$];
    ramp_step_t                  steps [$];
    int unsigned                 mismatches = 0;
    int unsigned                 send_idle_pct;
    int unsigned                 recv_stall_pct;
    int unsigned                 hold_left = 0;
    bit                          hold_go = 1'b0;
    bit                          hold_done = 1'b0;
    int unsigned                 quiet_cycles = 0;
    logic                        recv_ready_next;

    function automatic void queue_expected(input ramp_colour_t c);
        expected_colours.insert(expected_colours.size(), c);
    endfunction

    function automatic void add_step(input ramp_step_t s);
        steps.insert(steps.size(), s);
    endfunction

    function automatic logic [cri_pkg::CHAN_W-1:0] blend_channel(
        input logic [cri_pkg::CHAN_W-1:0] lo,
        input logic [cri_pkg::CHAN_W-1:0] hi,
        input int unsigned frac);
        int unsigned mix;
        mix = (int'(cri_pkg::RAMP_FULL) - frac) * lo + frac * hi;
        return cri_pkg::CHAN_W'(mix / int'(cri_pkg::RAMP_FULL));
    endfunction

    function automatic ramp_colour_t ramp_lookup(input logic [cri_pkg::INT_W-1:0] level);
        ramp_colour_t                c;
        int unsigned                 n;
        int unsigned                 scaled;
        int unsigned                 seg;
        int unsigned                 frac;
        logic [cri_pkg::COLOR_W-1:0] lo;
        logic [cri_pkg::COLOR_W-1:0] hi;
        c = '0;
        c.color_valid = 1'b1;
        if (level == '0)
            return c;
        n = (ramp_count > PALETTE_DEPTH) ? PALETTE_DEPTH : ramp_count;
        if (n == 0)
        begin
            c.color_valid = 1'b0;
            return c;
        end
        scaled = level * n;
        seg    = scaled / int'(cri_pkg::RAMP_FULL);
        frac   = scaled % int'(cri_pkg::RAMP_FULL);
        if (frac == 0)
        begin
            hi = ramp_palette[seg - 1];
            c.red   = hi[23:16];
            c.green = hi[15:8];
            c.blue  = hi[7:0];
            return c;
        end
        hi = ramp_palette[seg];
        lo = (seg > 0) ? ramp_palette[seg - 1] : '0;
        c.red   = blend_channel(lo[23:16], hi[23:16], frac);
        c.green = blend_channel(lo[15:8], hi[15:8], frac);
        c.blue  = blend_channel(lo[7:0], hi[7:0], frac);
        return c;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    endtask

    task automatic check_colour();
        ramp_colour_t want;
        if (expected_colours.size() == 0)
        begin
            report_mismatch("unexpected item", {8'd0, rsp_ch.red, rsp_ch.green, rsp_ch.blue}, 0);
            return;
        end
        want = expected_colours.pop_front();
        if (rsp_ch.red !== want.red)
            report_mismatch("red", rsp_ch.red, want.red);
        if (rsp_ch.green !== want.green)
            report_mismatch("green", rsp_ch.green, want.green);
        if (rsp_ch.blue !== want.blue)
            report_mismatch("blue", rsp_ch.blue, want.blue);
        if (rsp_ch.color_valid !== want.color_valid)
            report_mismatch("color_valid", rsp_ch.color_valid, want.color_valid);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            check_colour();
        if (hold_go && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            recv_ready_next = 1'b0;
            hold_left--;
        end
        else
            recv_ready_next = ($urandom_range(99) >= recv_stall_pct);
        rsp_ch.ready <= recv_ready_next;
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_request(input logic kind, input logic [cri_pkg::IDX_W-1:0] index,
                                input logic [cri_pkg::COLOR_W-1:0] colour,
                                input logic [cri_pkg::INT_W-1:0] level, input bit fixed,
                                input ramp_colour_t fixed_colour);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.entry_index <= index;
        req_ch.entry_color <= colour;
        req_ch.intensity   <= level;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (kind == cri_pkg::REQ_LOAD)
            ramp_palette[index] = colour;
        else
            queue_expected(fixed ? fixed_colour : ramp_lookup(level));
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (expected_colours.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [cri_pkg::COUNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        ramp_count  = value;
    endtask

    task automatic send_random_items(input int unsigned total);
        logic                        kind;
        logic [cri_pkg::COLOR_W-1:0] colour;
        logic [cri_pkg::INT_W-1:0]   level;
        int unsigned                 pick;
        for (int unsigned i = 0; i < total; i++)
        begin
            kind = ($urandom_range(3) == 0) ? cri_pkg::REQ_LOAD : cri_pkg::REQ_LOOKUP;
            pick = $urandom_range(9);
            colour = (pick == 0) ? '0 : (pick == 1) ? '1 : cri_pkg::COLOR_W'($urandom);
            pick = $urandom_range(9);
            level = (pick == 0) ? '0 : (pick == 1) ? '1
                                      : cri_pkg::INT_W'($urandom_range(255));
            push_request(kind, cri_pkg::IDX_W'($urandom_range(PALETTE_DEPTH - 1)), colour,
                         level, 1'b0, '0);
        end
    endtask

    function automatic ramp_step_t count_step(input logic [cri_pkg::COUNT_W-1:0] value);
        ramp_step_t s;
        s = '{STEP_COUNT, value, '0, '0, '0, 1'b0, '0};
        return s;
    endfunction

    function automatic ramp_step_t load_step(input logic [cri_pkg::IDX_W-1:0] index,
                                             input logic [cri_pkg::COLOR_W-1:0] colour);
        ramp_step_t s;
        s = '{STEP_LOAD, '0, index, colour, '0, 1'b0, '0};
        return s;
    endfunction

    function automatic ramp_step_t lookup_step(input logic [cri_pkg::INT_W-1:0] level,
                                               input bit fixed, input ramp_colour_t want);
        ramp_step_t s;
        s = '{STEP_LOOKUP, '0, '0, '0, level, fixed, want};
        return s;
    endfunction

    initial
    begin
        logic [cri_pkg::COUNT_W-1:0] phase_count [RANDOM_PHASES];
        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= cri_pkg::REQ_LOOKUP;
        req_ch.entry_index <= '0;
        req_ch.entry_color <= '0;
        req_ch.intensity   <= '0;
        ramp_count     = '0;
        send_idle_pct  = 12;
        recv_stall_pct = 74;
        foreach (ramp_palette[i])
            ramp_palette[i] = '0;

        add_step(lookup_step(8'd0, 1'b1, {8'h00, 8'h00, 8'h00, 1'b1}));
        add_step(lookup_step(8'd255, 1'b1, {8'h00, 8'h00, 8'h00, 1'b0}));
        add_step(load_step(4'd0, 24'hFFFFFF));
        for (int i = 1; i < PALETTE_DEPTH - 1; i++)
            add_step(load_step(cri_pkg::IDX_W'(i),
                               {8'(i * 17), 8'(8'hA5 ^ i), 8'(255 - i * 16)}));
        add_step(load_step(4'd15, 24'h00FF80));
        add_step(count_step(5'd1));
        add_step(lookup_step(8'd255, 1'b1, {8'hFF, 8'hFF, 8'hFF, 1'b1}));
        add_step(lookup_step(8'd1, 1'b0, '0));
        add_step(count_step(5'd16));
        add_step(lookup_step(8'd255, 1'b1, {8'h00, 8'hFF, 8'h80, 1'b1}));
        add_step(lookup_step(8'd16, 1'b0, '0));
        add_step(lookup_step(8'd1, 1'b0, '0));
        add_step(count_step(5'd31));
        add_step(lookup_step(8'd255, 1'b1, {8'h00, 8'hFF, 8'h80, 1'b1}));
        add_step(lookup_step(8'd128, 1'b0, '0));
        add_step(count_step(5'd5));
        add_step(lookup_step(8'd51, 1'b1, {8'hFF, 8'hFF, 8'hFF, 1'b1}));
        add_step(lookup_step(8'd100, 1'b0, '0));
        add_step(count_step(5'd0));
        add_step(lookup_step(8'd200, 1'b1, {8'h00, 8'h00, 8'h00, 1'b0}));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
        begin
            case (steps[i].kind)
                STEP_COUNT:
                begin
                    settle();
                    write_count(steps[i].count);
                end
                STEP_LOAD:
                    push_request(cri_pkg::REQ_LOAD, steps[i].index, steps[i].colour,
                                 cri_pkg::INT_W'($urandom), 1'b0, '0);
                default:
                    push_request(cri_pkg::REQ_LOOKUP, cri_pkg::IDX_W'($urandom),
                                 cri_pkg::COLOR_W'($urandom), steps[i].level,
                                 steps[i].fixed, steps[i].fixed_colour);
            endcase
        end

        phase_count = '{5'd16, 5'd1, 5'd8, 5'd0, 5'd15,
                        cri_pkg::COUNT_W'($urandom_range(2, PALETTE_DEPTH - 2))};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            if (p == 2)
            begin
                send_idle_pct  = 74;
                recv_stall_pct = 12;
            end
            else if (p == 4)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_count(phase_count[p]);
            // hold the output while the input keeps offering, so the pipeline fills
            if (p == 4)
                hold_go = 1'b1;
            send_random_items(PHASE_ITEMS);
        end
        settle();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/cri_pkg.sv
hdl/cri_if.sv
hdl/cri_scale.sv
hdl/cri_palette.sv
hdl/cri_blend.sv
hdl/color_ramp_interpolator.sv
tb/sv/tb_color_ramp_interpolator.sv
